// ===== rtl/wsg_pkg.sv =====
// Shared widths, codes and pipeline record types for the waveform sample generator.
package wsg_pkg;

  localparam int TB       = 32;
  localparam int TB_IW    = $clog2(TB);
  localparam int RATE_W   = 18;
  localparam int NOTE_W   = 16;
  localparam int AMP_W    = 16;
  localparam int HALF_W   = RATE_W - 1;
  localparam int SMP_W    = AMP_W + 1;
  localparam int NUM_W    = 3 * HALF_W;
  localparam int X_W      = NUM_W + AMP_W;
  localparam int POS_W    = 5;
  localparam int P_STEPS  = RATE_W;
  localparam int M_STEPS  = TB;
  localparam int Q_STEPS  = SMP_W;
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = RATE_W;

  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(44100);
  localparam logic [AMP_W-1:0]  AMP_RST  = AMP_W'(256);

  typedef enum logic [1:0] {
    MODE_SQUARE = 2'd0,
    MODE_SAW    = 2'd1,
    MODE_TRI    = 2'd2,
    MODE_POLY   = 2'd3
  } wave_mode_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_PEAK_LEVEL  = 2'd1,
    REG_WAVE_MODE   = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              vld;
    logic [NOTE_W-1:0] note;
    logic [TB-1:0]     tm;
    logic [RATE_W-1:0] rem;
    logic [RATE_W-1:0] quo;
  } pdiv_t;

  typedef struct packed {
    logic              vld;
    logic [RATE_W-1:0] per;
    logic [TB-1:0]     tm;
    logic [RATE_W-1:0] rt;
    logic [HALF_W-1:0] ru;
  } pmod_t;

  typedef struct packed {
    logic             vld;
    logic             err;
    logic             flip;
    logic [X_W-1:0]   rem;
    logic [NUM_W-1:0] den;
    logic [SMP_W-1:0] quo;
  } qdiv_t;

endpackage

// ===== rtl/waveform_sample_generator_core.sv =====
// Top level of the waveform sample generator: configuration, cell chains and output register.
//
//  channel | direction | handshake                 | payload
//  in      | in        | in_valid / in_ready       | note_hz, sample_index
//  out     | out       | out_valid / out_ready     | sample_value, period_error
//  cfg     | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One transaction enters per cycle while the output is not stalled, and passes in order through
// the bit-per-cell period and phase chains, the product stages, the quotient divider chain and the output register.
// Reset clears all valid flags and loads the configuration defaults.
// A stalled output freezes the whole chain; in_ready drops only while out_valid waits.
module waveform_sample_generator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wsg_pkg::NOTE_W-1:0]    note_hz,
  input  logic [31:0]                   sample_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wsg_pkg::SMP_W-1:0]     sample_value,
  output logic                          period_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsg_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [wsg_pkg::CDATA_W-1:0]   cfg_data
);

  logic [wsg_pkg::RATE_W-1:0] sample_rate;
  logic [wsg_pkg::AMP_W-1:0]  peak_level;
  wsg_pkg::wave_mode_t        wave_mode;
  logic                       en;
  logic [wsg_pkg::SMP_W-1:0]  sample_next;

  wsg_pkg::pdiv_t pd [0:wsg_pkg::P_STEPS];
  wsg_pkg::pmod_t pm [0:wsg_pkg::M_STEPS];
  wsg_pkg::qdiv_t qd [0:wsg_pkg::Q_STEPS];

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= wsg_pkg::RATE_RST;
      peak_level  <= wsg_pkg::AMP_RST;
      wave_mode   <= wsg_pkg::MODE_SQUARE;
    end else if (cfg_valid) begin
      case (wsg_pkg::cfg_reg_t'(cfg_index))
        wsg_pkg::REG_SAMPLE_RATE: sample_rate <= cfg_data;
        wsg_pkg::REG_PEAK_LEVEL:  peak_level  <= cfg_data[wsg_pkg::AMP_W-1:0];
        wsg_pkg::REG_WAVE_MODE:   wave_mode   <= wsg_pkg::wave_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    pd[0].vld  = in_valid;
    pd[0].note = note_hz;
    pd[0].tm   = sample_index[wsg_pkg::TB-1:0];
    pd[0].rem  = '0;
    pd[0].quo  = '0;
  end

  for (genvar i = 0; i < wsg_pkg::P_STEPS; i++) begin : g_pdiv
    wsg_pdiv_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .pos  (wsg_pkg::POS_W'(wsg_pkg::P_STEPS - 1 - i)),
      .rate (sample_rate),
      .d    (pd[i]),
      .q    (pd[i+1])
    );
  end

  always_comb begin
    pm[0].vld = pd[wsg_pkg::P_STEPS].vld;
    pm[0].per = pd[wsg_pkg::P_STEPS].quo;
    pm[0].tm  = pd[wsg_pkg::P_STEPS].tm;
    pm[0].rt  = '0;
    pm[0].ru  = '0;
  end

  for (genvar i = 0; i < wsg_pkg::M_STEPS; i++) begin : g_mod
    wsg_mod_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .pos (wsg_pkg::TB_IW'(wsg_pkg::M_STEPS - 1 - i)),
      .d   (pm[i]),
      .q   (pm[i+1])
    );
  end

  wsg_prep u_prep (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .mode (wave_mode),
    .amp  (peak_level),
    .d    (pm[wsg_pkg::M_STEPS]),
    .q    (qd[0])
  );

  for (genvar i = 0; i < wsg_pkg::Q_STEPS; i++) begin : g_qdiv
    wsg_qdiv_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .pos (wsg_pkg::POS_W'(wsg_pkg::Q_STEPS - 1 - i)),
      .d   (qd[i]),
      .q   (qd[i+1])
    );
  end

  always_comb begin
    if (qd[wsg_pkg::Q_STEPS].err) begin
      sample_next = '0;
    end else if (qd[wsg_pkg::Q_STEPS].flip) begin
      sample_next = wsg_pkg::SMP_W'({1'b0, peak_level} - qd[wsg_pkg::Q_STEPS].quo);
    end else begin
      sample_next = qd[wsg_pkg::Q_STEPS].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= qd[wsg_pkg::Q_STEPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_value <= sample_next;
      period_error <= qd[wsg_pkg::Q_STEPS].err;
    end
  end

endmodule

// ===== rtl/wsg_pdiv_cell.sv =====
// One restoring step of the period division sample_rate / note_hz.
module wsg_pdiv_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [wsg_pkg::POS_W-1:0]    pos,
  input  logic [wsg_pkg::RATE_W-1:0]   rate,
  input  wsg_pkg::pdiv_t               d,
  output wsg_pkg::pdiv_t               q
);

  logic [wsg_pkg::RATE_W:0] trial;
  logic [wsg_pkg::RATE_W:0] dvs;
  logic                     hit;
  wsg_pkg::pdiv_t           q_next;

  always_comb begin
    trial  = {d.rem, rate[pos]};
    dvs    = {{(wsg_pkg::RATE_W + 1 - wsg_pkg::NOTE_W){1'b0}}, d.note};
    hit    = (d.note != '0) && (trial >= dvs);
    q_next = d;
    if (hit) begin
      q_next.rem      = wsg_pkg::RATE_W'(trial - dvs);
      q_next.quo[pos] = 1'b1;
    end else begin
      q_next.rem = trial[wsg_pkg::RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q.vld <= d.vld;
    end
    if (en) begin
      q.note <= q_next.note;
      q.tm   <= q_next.tm;
      q.rem  <= q_next.rem;
      q.quo  <= q_next.quo;
    end
  end

endmodule

// ===== rtl/wsg_mod_cell.sv =====
// One restoring step of the phase remainders: time mod period and time mod half-period.
module wsg_mod_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [wsg_pkg::TB_IW-1:0] pos,
  input  wsg_pkg::pmod_t            d,
  output wsg_pkg::pmod_t            q
);

  logic [wsg_pkg::RATE_W:0]   trial_t;
  logic [wsg_pkg::HALF_W:0]   trial_u;
  logic [wsg_pkg::HALF_W-1:0] half;
  wsg_pkg::pmod_t             q_next;

  always_comb begin
    half    = d.per[wsg_pkg::RATE_W-1:1];
    trial_t = {d.rt, d.tm[pos]};
    trial_u = {d.ru, d.tm[pos]};
    q_next  = d;
    if (trial_t >= {1'b0, d.per}) begin
      q_next.rt = wsg_pkg::RATE_W'(trial_t - {1'b0, d.per});
    end else begin
      q_next.rt = trial_t[wsg_pkg::RATE_W-1:0];
    end
    if (trial_u >= {1'b0, half}) begin
      q_next.ru = wsg_pkg::HALF_W'(trial_u - {1'b0, half});
    end else begin
      q_next.ru = trial_u[wsg_pkg::HALF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q.vld <= d.vld;
    end
    if (en) begin
      q.per <= q_next.per;
      q.tm  <= q_next.tm;
      q.rt  <= q_next.rt;
      q.ru  <= q_next.ru;
    end
  end

endmodule

// ===== rtl/wsg_prep.sv =====
// Product stages that form the dividend and divisor of the sample quotient per mode.
module wsg_prep (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  wsg_pkg::wave_mode_t         mode,
  input  logic [wsg_pkg::AMP_W-1:0]   amp,
  input  wsg_pkg::pmod_t              d,
  output wsg_pkg::qdiv_t              q
);

  localparam int HW = wsg_pkg::HALF_W;
  localparam int RW = wsg_pkg::RATE_W;
  localparam int AW = wsg_pkg::AMP_W;
  localparam int NW = wsg_pkg::NUM_W;
  localparam int XW = wsg_pkg::X_W;
  localparam int WW = HW + 2;

  // stage 1
  logic [HW-1:0]      h0;
  logic [RW-1:0]      linop;
  logic               s1_vld, s1_err, s1_flip;
  logic [RW-1:0]      s1_per;
  logic [HW-1:0]      s1_h;
  logic [RW+AW-1:0]   s1_lin;
  logic [AW-1:0]      s1_sq;
  logic [2*HW-1:0]    s1_uu, s1_hh;
  logic [WW-1:0]      s1_w;
  // stage 2
  logic               s2_vld, s2_err, s2_flip;
  logic [RW-1:0]      s2_per;
  logic [HW-1:0]      s2_h;
  logic [RW+AW-1:0]   s2_lin;
  logic [AW-1:0]      s2_sq;
  logic [HW+WW-1:0]   s2_pl, s2_ph;
  logic [2*HW-1:0]    s2_cl, s2_ch;
  // stage 3
  logic               s3_vld, s3_err, s3_flip;
  logic [RW-1:0]      s3_per;
  logic [HW-1:0]      s3_h;
  logic [RW+AW-1:0]   s3_lin;
  logic [AW-1:0]      s3_sq;
  logic [NW-1:0]      s3_num, s3_den;
  // stage 4
  logic               s4_vld, s4_err, s4_flip;
  logic [RW-1:0]      s4_per;
  logic [HW-1:0]      s4_h;
  logic [RW+AW-1:0]   s4_lin;
  logic [AW-1:0]      s4_sq;
  logic [NW-1:0]      s4_den;
  logic [AW+HW-1:0]   s4_a0, s4_a1, s4_a2;
  // stage 5
  logic [XW-1:0]      x_next;
  logic [NW-1:0]      den_next;

  always_comb begin
    h0 = d.per[RW-1:1];
    case (mode)
      wsg_pkg::MODE_SAW: linop = d.rt;
      wsg_pkg::MODE_TRI: linop = (d.rt < {1'b0, h0}) ? d.rt : RW'(d.per - d.rt);
      default:           linop = '0;
    endcase
  end

  always_comb begin
    x_next   = '0;
    den_next = NW'(1);
    case (mode)
      wsg_pkg::MODE_SQUARE: begin
        x_next = XW'(s4_sq);
      end
      wsg_pkg::MODE_SAW: begin
        x_next   = XW'(s4_lin);
        den_next = NW'(s4_per);
      end
      wsg_pkg::MODE_TRI: begin
        x_next   = XW'(s4_lin);
        den_next = NW'(s4_h);
      end
      wsg_pkg::MODE_POLY: begin
        x_next   = XW'(s4_a0) + (XW'(s4_a1) << HW) + (XW'(s4_a2) << (2 * HW));
        den_next = s4_den;
      end
      default: begin
        x_next = '0;
      end
    endcase
    if (s4_err) begin
      x_next   = '0;
      den_next = NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      q.vld  <= 1'b0;
    end else if (en) begin
      s1_vld <= d.vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      q.vld  <= s4_vld;
    end
    if (en) begin
      s1_err  <= (d.per == '0) || (mode[1] && (h0 == '0));
      s1_flip <= (mode == wsg_pkg::MODE_POLY) && (d.rt > {1'b0, h0});
      s1_per  <= d.per;
      s1_h    <= h0;
      s1_lin  <= linop * amp;
      s1_sq   <= (d.rt < {1'b0, h0}) ? amp : '0;
      s1_uu   <= d.ru * d.ru;
      s1_hh   <= h0 * h0;
      s1_w    <= WW'(WW'(h0) * WW'(3) - {1'b0, d.ru, 1'b0});

      s2_err  <= s1_err;
      s2_flip <= s1_flip;
      s2_per  <= s1_per;
      s2_h    <= s1_h;
      s2_lin  <= s1_lin;
      s2_sq   <= s1_sq;
      s2_pl   <= s1_uu[HW-1:0] * s1_w;
      s2_ph   <= s1_uu[2*HW-1:HW] * s1_w;
      s2_cl   <= s1_hh[HW-1:0] * s1_h;
      s2_ch   <= s1_hh[2*HW-1:HW] * s1_h;

      s3_err  <= s2_err;
      s3_flip <= s2_flip;
      s3_per  <= s2_per;
      s3_h    <= s2_h;
      s3_lin  <= s2_lin;
      s3_sq   <= s2_sq;
      s3_num  <= NW'(NW'(s2_pl) + (NW'(s2_ph) << HW));
      s3_den  <= NW'(NW'(s2_cl) + (NW'(s2_ch) << HW));

      s4_err  <= s3_err;
      s4_flip <= s3_flip;
      s4_per  <= s3_per;
      s4_h    <= s3_h;
      s4_lin  <= s3_lin;
      s4_sq   <= s3_sq;
      s4_den  <= s3_den;
      s4_a0   <= amp * s3_num[HW-1:0];
      s4_a1   <= amp * s3_num[2*HW-1:HW];
      s4_a2   <= amp * s3_num[3*HW-1:2*HW];

      q.err   <= s4_err;
      q.flip  <= s4_flip;
      q.rem   <= x_next;
      q.den   <= den_next;
      q.quo   <= '0;
    end
  end

endmodule

// ===== rtl/wsg_qdiv_cell.sv =====
// One restoring step of the sample quotient dividend / divisor.
module wsg_qdiv_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [wsg_pkg::POS_W-1:0] pos,
  input  wsg_pkg::qdiv_t            d,
  output wsg_pkg::qdiv_t            q
);

  localparam int XW = wsg_pkg::X_W;

  logic [XW:0]    dsh;
  wsg_pkg::qdiv_t q_next;

  always_comb begin
    dsh    = (XW + 1)'(d.den) << pos;
    q_next = d;
    if ({1'b0, d.rem} >= dsh) begin
      q_next.rem      = XW'({1'b0, d.rem} - dsh);
      q_next.quo[pos] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q.vld <= d.vld;
    end
    if (en) begin
      q.err  <= q_next.err;
      q.flip <= q_next.flip;
      q.rem  <= q_next.rem;
      q.den  <= q_next.den;
      q.quo  <= q_next.quo;
    end
  end

endmodule

// ===== rtl/wsg_checker.sv =====
// Port-level assertions for the waveform sample generator and their binding.
module wsg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wsg_pkg::SMP_W-1:0]   sample_value,
  input logic                        period_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(sample_value) && $stable(period_error))
    else $error("output payload changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && period_error |-> sample_value == '0)
    else $error("nonzero sample with period error");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind waveform_sample_generator_core wsg_checker u_wsg_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .sample_value (sample_value),
  .period_error (period_error)
);
